[src/cbcs_pattern_aes_cbc_encryptor_defines.svh]
// assertion helpers
`ifndef CBCS_PATTERN_AES_CBC_ENCRYPTOR_DEFINES_SVH
`define CBCS_PATTERN_AES_CBC_ENCRYPTOR_DEFINES_SVH
`define CBCS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define CBCS_NEVER(lbl, cond) \
    `CBCS_ASSERT(lbl, !(cond))
`endif

[src/cbcs_pkg.sv]
`default_nettype none
package cbcs_pkg;
    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
        logic        first_of_sample;
        logic [23:0] bytes_left;
    } t_in;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_count;
        logic        was_encrypted;
    } t_out;

    // classified word handed from front to back
    typedef struct packed {
        logic [127:0] data;
        logic [4:0]   count;
        logic         enc;
        logic         restart;
    } t_job;

    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_IV_HIGH  = 3'd2;
    localparam logic [2:0] REG_IV_LOW   = 3'd3;
    localparam logic [2:0] REG_CRYPT    = 3'd4;
    localparam logic [2:0] REG_SKIP     = 3'd5;

    localparam logic [4:0] BLOCK_BYTES = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the state sits at bits [127-8i -: 8]
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[4*c+i] = SBOX[s[127 - 8*(4*((c+i)%4)+i) -: 8]];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = t[i];
        end
        aes_round = r ^ rk;
    endfunction

    function automatic logic [127:0] key_next(input logic [127:0] k,
                                              input logic [7:0]   rcon);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        tw = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        key_next = {w0, w1, w2, w3};
    endfunction
endpackage
`default_nettype wire

[src/cbcs_pattern_aes_cbc_encryptor.sv]
// Clear words pass the queue and output register; encrypted words
// also the AES round state, one at a time. Clear words 1 per cycle
// while popped; the single AES round unit does one round per cycle.
// Reset: i_rst_n synchronous active low; key/IV zero, crypt 1, skip 9,
// chain and pattern position zero, queues empty.
`default_nettype none
`include "cbcs_pattern_aes_cbc_encryptor_defines.svh"
module cbcs_pattern_aes_cbc_encryptor #(
    parameter int PATTERN_BLOCKS     = 10,
    parameter int SAMPLE_LENGTH_BITS = 24
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              push,
    output logic             full,
    input  cbcs_pkg::t_in    i_data,
    output logic             empty,
    input  wire              pop,
    output cbcs_pkg::t_out   o_data,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire [5:0]        paddr,
    input  wire [63:0]       pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    logic [63:0] r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic [3:0]  r_crypt, r_skip;
    logic        wr;
    logic [2:0]  idx;
    cbcs_pkg::t_job job_f, job_q;
    logic        q_empty, q_pop;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
            r_crypt    <= 4'd1;
            r_skip     <= 4'd9;
        end else if (wr) begin
            case (idx)
                cbcs_pkg::REG_KEY_HIGH: r_key_high <= pwdata;
                cbcs_pkg::REG_KEY_LOW:  r_key_low  <= pwdata;
                cbcs_pkg::REG_IV_HIGH:  r_iv_high  <= pwdata;
                cbcs_pkg::REG_IV_LOW:   r_iv_low   <= pwdata;
                cbcs_pkg::REG_CRYPT:    r_crypt    <= pwdata[3:0];
                cbcs_pkg::REG_SKIP:     r_skip     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            cbcs_pkg::REG_KEY_HIGH: prdata = r_key_high;
            cbcs_pkg::REG_KEY_LOW:  prdata = r_key_low;
            cbcs_pkg::REG_IV_HIGH:  prdata = r_iv_high;
            cbcs_pkg::REG_IV_LOW:   prdata = r_iv_low;
            cbcs_pkg::REG_CRYPT:    prdata = {60'd0, r_crypt};
            cbcs_pkg::REG_SKIP:     prdata = {60'd0, r_skip};
            default:                prdata = '0;
        endcase
    end

    cbcs_front #(
        .PATTERN_BLOCKS     (PATTERN_BLOCKS),
        .SAMPLE_LENGTH_BITS (SAMPLE_LENGTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push),
        .i_item  (i_data),
        .i_take  (!full),
        .i_crypt (r_crypt),
        .i_skip  (r_skip),
        .o_job   (job_f)
    );

    cbcs_queue #(.DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (job_f),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_word  (job_q)
    );

    cbcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_job   (job_q),
        .o_pop   (q_pop),
        .i_key   ({r_key_high, r_key_low}),
        .i_iv    ({r_iv_high, r_iv_low}),
        .o_empty (empty),
        .o_word  (o_data),
        .i_pop   (pop)
    );

    `CBCS_NEVER(a_no_pop_empty_q, q_pop && q_empty)
    `CBCS_ASSERT(a_out_hold, (!empty && !pop) |=> (!empty && $stable(o_data)))
    `CBCS_NEVER(a_enc_full_count, !empty && o_data.was_encrypted &&
                o_data.out_count != cbcs_pkg::BLOCK_BYTES)
endmodule
`default_nettype wire

[src/cbcs_front.sv]
`default_nettype none
module cbcs_front #(
    parameter int PATTERN_BLOCKS     = 10,
    parameter int SAMPLE_LENGTH_BITS = 24
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  cbcs_pkg::t_in    i_item,
    input  wire              i_take,
    input  wire [3:0]        i_crypt,
    input  wire [3:0]        i_skip,
    output cbcs_pkg::t_job   o_job
);
    localparam int PW = $clog2(PATTERN_BLOCKS + 1);
    localparam int LW = (SAMPLE_LENGTH_BITS < 24) ? SAMPLE_LENGTH_BITS : 24;

    logic [PW-1:0] r_pos, n_pos;
    logic          r_seg, n_seg;
    logic [4:0]    crypt_c, skip_c, period, room;
    logic [PW-1:0] pos0;
    logic [LW-1:0] left;
    logic [9:0]    thr;
    logic          enc;

    always_comb begin
        crypt_c = ({1'b0, i_crypt} > 5'(PATTERN_BLOCKS)) ? 5'(PATTERN_BLOCKS)
                                                         : {1'b0, i_crypt};
        room    = 5'(PATTERN_BLOCKS) - crypt_c;
        skip_c  = ({1'b0, i_skip} > room) ? room : {1'b0, i_skip};
        period  = crypt_c + skip_c;
        left    = i_item.bytes_left[LW-1:0];
        thr     = {1'b0, crypt_c, 4'd0};
        pos0    = i_item.first_of_sample ? '0 : r_pos;
        if (period == 5'd0 || 5'(pos0) >= period) begin
            pos0 = '0;
        end
        n_seg = r_seg;
        enc   = 1'b0;
        n_pos = pos0;
        if (period != 5'd0) begin
            if (pos0 == '0) begin
                n_seg = 24'(left) > 24'(thr);
            end
            enc   = (5'(pos0) < crypt_c) && n_seg &&
                    (i_item.byte_count == cbcs_pkg::BLOCK_BYTES);
            n_pos = (5'(pos0) + 5'd1 >= period) ? '0 : PW'(5'(pos0) + 5'd1);
        end
        o_job.data    = {i_item.data_high, i_item.data_low};
        o_job.count   = i_item.byte_count;
        o_job.enc     = enc;
        o_job.restart = i_item.first_of_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_seg <= 1'b0;
        end else if (i_valid && i_take) begin
            r_pos <= n_pos;
            r_seg <= n_seg;
        end
    end
endmodule
`default_nettype wire

[src/cbcs_queue.sv]
`default_nettype none
module cbcs_queue #(
    parameter int DEPTH = 2
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  cbcs_pkg::t_job  i_word,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output cbcs_pkg::t_job  o_word
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    cbcs_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule
`default_nettype wire

[src/cbcs_back.sv]
`default_nettype none
module cbcs_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_empty,
    input  cbcs_pkg::t_job  i_job,
    output logic            o_pop,
    input  wire [127:0]     i_key,
    input  wire [127:0]     i_iv,
    output logic            o_empty,
    output cbcs_pkg::t_out  o_word,
    input  wire             i_pop
);
    cbcs_pkg::t_state r_state, n_state;
    logic [127:0] r_s, n_s, r_k, n_k, r_chain, n_chain;
    logic [7:0]   r_rcon, n_rcon;
    logic [3:0]   r_rnd, n_rnd;
    logic [4:0]   r_cnt;
    logic         r_full, n_full;
    cbcs_pkg::t_out r_out, n_out;
    logic [127:0] kn, chain_in;
    logic         load;

    assign o_empty = !r_full;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbcs_pkg::ST_IDLE;
            r_full  <= 1'b0;
            r_chain <= '0;
        end else begin
            r_state <= n_state;
            r_full  <= n_full;
            r_chain <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_k    <= n_k;
        r_rcon <= n_rcon;
        r_rnd  <= n_rnd;
        r_out  <= n_out;
        if (load) begin
            r_cnt <= i_job.count;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_s      = r_s;
        n_k      = r_k;
        n_rcon   = r_rcon;
        n_rnd    = r_rnd;
        n_out    = r_out;
        n_chain  = r_chain;
        n_full   = r_full && !i_pop;
        o_pop    = 1'b0;
        load     = 1'b0;
        chain_in = i_job.restart ? i_iv : r_chain;
        kn       = cbcs_pkg::key_next(r_k, r_rcon);
        case (r_state)
            cbcs_pkg::ST_IDLE: begin
                // output slot frees this cycle or is free already
                if (!i_empty && !n_full) begin
                    o_pop = 1'b1;
                    if (i_job.enc) begin
                        load    = 1'b1;
                        n_s     = i_job.data ^ chain_in ^ i_key;
                        n_k     = i_key;
                        n_rcon  = 8'h01;
                        n_rnd   = 4'd1;
                        n_chain = chain_in;
                        n_state = cbcs_pkg::ST_RUN;
                    end else begin
                        if (i_job.restart) begin
                            n_chain = i_iv;
                        end
                        n_out  = {i_job.data, i_job.count, 1'b0};
                        n_full = 1'b1;
                    end
                end
            end
            cbcs_pkg::ST_RUN: begin
                n_s    = cbcs_pkg::aes_round(r_s, kn, r_rnd == 4'd10);
                n_k    = kn;
                n_rcon = cbcs_pkg::xt(r_rcon);
                n_rnd  = r_rnd + 4'd1;
                if (r_rnd == 4'd10) begin
                    n_state = cbcs_pkg::ST_DONE;
                end
            end
            cbcs_pkg::ST_DONE: begin
                if (!n_full) begin
                    n_out   = {r_s, r_cnt, 1'b1};
                    n_full  = 1'b1;
                    n_chain = r_s;
                    n_state = cbcs_pkg::ST_IDLE;
                end
            end
            default: n_state = cbcs_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire
